### rtl/core/gelu_pkg.sv
// ----------------------------------------------------------------------------
// gelu_pkg
// Shared constants, the stage control type and the erf / tanh knot tables
// for the GELU activation pipeline. The tables are built at elaboration
// from integer series, so they follow TABLE_BITS.
// ----------------------------------------------------------------------------
package gelu_pkg;

  // number format and table size
  localparam int FRAC_BITS  = 12;
  localparam int TABLE_BITS = 8;

  localparam int SAMPLE_W  = 16;
  localparam int ROM_W     = 17;                       // Q16, 1.0 = 65536
  localparam int ROM_DEPTH = 1 << TABLE_BITS;          // knots 0 .. 2^TABLE_BITS-1
  localparam int ROM_AW    = TABLE_BITS;

  // the knot at the end of the table is the clamp value
  localparam logic [ROM_W-1:0] KNOT_ONE = ROM_W'(65536);

  // Q30 constants
  localparam int K_W  = 30;
  localparam int C3_W = 26;
  localparam logic [K_W-1:0]  K_ISQ2 = 30'd759250124;   // 1/sqrt2
  localparam logic [K_W-1:0]  K_S2PI = 30'd856722023;   // sqrt(2/pi)
  localparam logic [C3_W-1:0] C3     = 26'd48012365;    // 0.044715
  localparam logic [63:0]     K_2SQPI = 64'd1211587905; // 2/sqrt(pi)
  localparam logic [63:0]     ONE_Q30 = 64'd1 << 30;

  // table kinds
  localparam int KIND_ERF  = 0;
  localparam int KIND_TANH = 1;

  // mode register codes
  localparam logic MODE_ERF  = 1'b0;
  localparam logic MODE_TANH = 1'b1;

  typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] rom_t;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic                v;
    logic                neg;
    logic                mode;
    logic                big;
    logic [SAMPLE_W-1:0] a;
  } ctl_t;

  // unsigned quotient by long division, only used while building the tables
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor(num * 2^bits / den) for num < den, restoring division
  function automatic logic [63:0] frac_div(logic [63:0] num_i, logic [63:0] den, int bits);
    logic [63:0] num;
    logic [63:0] q;
    num = num_i;
    q   = 64'd0;
    if (den == 64'd0 || num >= den) begin
      return 64'd1 << bits;
    end
    for (int i = 0; i < bits; i++) begin
      num = num << 1;
      q   = q << 1;
      if (num >= den) begin
        num = num - den;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // e^w in Q30, w = k/2^ds or (k/2^ds)^2 when sq is set
  function automatic logic [63:0] exp_q30(logic [63:0] k, int ds, bit sq);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd0;
    term = ONE_Q30;
    for (int n = 1; n < 400; n++) begin
      if (term != 64'd0) begin
        sum  = sum + term;
        term = div_u64(term * k, 64'(n) << ds);
        if (sq) begin
          term = (term * k) >> ds;
        end
      end
    end
    return sum;
  endfunction

  // one knot of the erf or tanh table, Q16
  function automatic logic [ROM_W-1:0] knot(int kind, logic [63:0] k);
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] r;
    logic [63:0] p;
    s = 64'd0;
    if (k >= (64'd1 << TABLE_BITS)) begin
      return ROM_W'(65536);
    end
    if (kind == KIND_ERF) begin
      // beyond 3.5 the rounded erf is exactly one
      if (64'd8 * k >= 64'd7 * (64'd1 << TABLE_BITS)) begin
        return ROM_W'(65536);
      end
      term = k << (32 - TABLE_BITS);
      for (int n = 1; n < 400; n++) begin
        if (term != 64'd0) begin
          s    = s + term;
          term = (term * k) >> (TABLE_BITS - 2);
          term = div_u64(term * 64'd2 * k, 64'(2 * n + 1) << (TABLE_BITS - 2));
        end
      end
      e = exp_q30(k, TABLE_BITS - 2, 1'b1);
      r = frac_div(s, e, 30);
      p = (K_2SQPI * r + (64'd1 << 43)) >> 44;
      return (p > 64'd65536) ? ROM_W'(65536) : ROM_W'(p);
    end else begin
      e = exp_q30(k, TABLE_BITS - 3, 1'b0);
      r = frac_div(e - ONE_Q30, e + ONE_Q30, 30);
      return ROM_W'((r + (64'd1 << 13)) >> 14);
    end
  endfunction

  function automatic rom_t build_rom(int kind);
    rom_t rom;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      rom[k] = knot(kind, 64'(k));
    end
    return rom;
  endfunction

  localparam rom_t ERF_ROM  = build_rom(KIND_ERF);
  localparam rom_t TANH_ROM = build_rom(KIND_TANH);

endpackage

### rtl/core/gelu_activation_unit.sv
// ----------------------------------------------------------------------------
// gelu_activation_unit
// Element-wise GELU on signed fixed-point samples, erf or tanh form, with
// table lookup and linear interpolation in a nine-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------
//  input     start, busy, in_sample_in               taken when start && !busy
//  result    out_strobe, out_sample_out              one cycle, cannot stall
//  config    cfg_wr_en, cfg_wr_data                  written when cfg_wr_en
//
//  one item enters per clock; busy stays low, the pipeline never stalls
//  each result appears in the order in which its item was taken
//  latency is set by the multiplier chain of the tanh argument
//  (a*a, *c, *a, *sqrt(2/pi)) followed by interpolation and final scaling
//  synchronous active-low reset clears the valid bits and the mode register
//
module gelu_activation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [gelu_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                              out_strobe,
  output logic signed [gelu_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);

  localparam int A_W     = gelu_pkg::SAMPLE_W;
  localparam int UE_W    = A_W + gelu_pkg::K_W;
  localparam int AA_W    = 2 * A_W;
  localparam int AAC_W   = AA_W + gelu_pkg::C3_W;
  localparam int Q_W     = 32;
  localparam int P_W     = A_W + Q_W;
  localparam int PS_W    = 32;
  localparam int UT_W    = PS_W + gelu_pkg::K_W;
  localparam int TB      = gelu_pkg::TABLE_BITS;
  localparam int ERF_SH  = gelu_pkg::FRAC_BITS + 30 - TB + 2;
  localparam int TANH_SH = gelu_pkg::FRAC_BITS + 44 - TB + 2;
  localparam int RW      = gelu_pkg::ROM_W;
  localparam int G_W     = 33;
  localparam int GS_W    = 35;
  localparam int M_W     = 34;
  localparam int N_W     = A_W + M_W;
  localparam int MAG_W   = A_W + 1;
  localparam int LATENCY = 9;

  localparam logic [A_W:0]     TANH_BIG = (A_W + 1)'(6 << gelu_pkg::FRAC_BITS);
  localparam logic [G_W-1:0]   G_ONE    = G_W'(64'd1 << 32);
  localparam logic [M_W-1:0]   M_ONE    = M_W'(64'd1 << 32);
  localparam logic [N_W-1:0]   N_HALF   = N_W'(64'd1 << 32);
  localparam logic [Q_W-1:0]   Q_ONE    = Q_W'(64'd1 << 30);

  // mode register
  logic mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gelu_pkg::MODE_ERF;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // stage control registers
  gelu_pkg::ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  gelu_pkg::ctl_t s5_ctl_r, s6_ctl_r, s7_ctl_r, s8_ctl_r;
  gelu_pkg::ctl_t s1_ctl_nxt;

  // stage 1 input: magnitude, sign and form
  always_comb begin
    s1_ctl_nxt.v    = start && !busy;
    s1_ctl_nxt.neg  = in_sample_in[A_W-1];
    s1_ctl_nxt.mode = mode_r;
    s1_ctl_nxt.a    = in_sample_in[A_W-1] ? A_W'(A_W'(0) - A_W'(in_sample_in))
                                          : A_W'(in_sample_in);
    s1_ctl_nxt.big  = {1'b0, s1_ctl_nxt.a} >= TANH_BIG;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
      s5_ctl_r <= '0;
      s6_ctl_r <= '0;
      s7_ctl_r <= '0;
      s8_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
      s5_ctl_r <= s4_ctl_r;
      s6_ctl_r <= s5_ctl_r;
      s7_ctl_r <= s6_ctl_r;
      s8_ctl_r <= s7_ctl_r;
    end
  end

  // stage 2: erf argument and x squared
  logic [UE_W-1:0] ue_nxt;
  logic [AA_W-1:0] aa_nxt;
  logic [UE_W-1:0] s2_ue_r, s3_ue_r, s4_ue_r, s5_ue_r;
  logic [AA_W-1:0] s2_aa_r;

  assign ue_nxt = s1_ctl_r.a * gelu_pkg::K_ISQ2;
  assign aa_nxt = s1_ctl_r.a * s1_ctl_r.a;

  always_ff @(posedge clk) begin
    s2_ue_r <= ue_nxt;
    s2_aa_r <= aa_nxt;
    s3_ue_r <= s2_ue_r;
    s4_ue_r <= s3_ue_r;
    s5_ue_r <= s4_ue_r;
  end

  // stage 3: cubic coefficient term c*x^2 in Q30
  logic [AAC_W-1:0] aac;
  logic [Q_W-1:0]   q_nxt;
  logic [Q_W-1:0]   s3_q_r;

  assign aac   = s2_aa_r * gelu_pkg::C3;
  assign q_nxt = Q_W'(aac >> (2 * gelu_pkg::FRAC_BITS));

  always_ff @(posedge clk) begin
    s3_q_r <= q_nxt;
  end

  // stage 4: x*(1 + c*x^2)
  logic [Q_W-1:0]  qsum;
  logic [P_W-1:0]  p_prod;
  logic [PS_W-1:0] ps_nxt;
  logic [PS_W-1:0] s4_ps_r;

  assign qsum   = Q_ONE + s3_q_r;
  assign p_prod = s3_ctl_r.a * qsum;
  assign ps_nxt = PS_W'(p_prod >> 16);

  always_ff @(posedge clk) begin
    s4_ps_r <= ps_nxt;
  end

  // stage 5: tanh argument
  logic [UT_W-1:0] ut_nxt;
  logic [UT_W-1:0] s5_ut_r;

  assign ut_nxt = s4_ps_r * gelu_pkg::K_S2PI;

  always_ff @(posedge clk) begin
    s5_ut_r <= ut_nxt;
  end

  // stage 6: knot index, weight and table read
  logic [TB-1:0]          e_idx, t_idx, idx;
  logic                   e_over, t_over;
  logic [15:0]            e_f, t_f;
  logic [gelu_pkg::ROM_AW-1:0] k0, k1;
  logic                   sat_nxt;
  logic [RW-1:0]          t0_nxt, t1_nxt;
  logic [15:0]            f_nxt;
  logic                   s6_sat_r;
  logic [RW-1:0]          s6_t0_r, s6_t1_r;
  logic [15:0]            s6_f_r;

  always_comb begin
    e_idx  = TB'(s5_ue_r >> ERF_SH);
    e_over = (s5_ue_r >> (ERF_SH + TB)) != '0;
    e_f    = 16'(s5_ue_r >> (ERF_SH - 16));
    t_idx  = TB'(s5_ut_r >> TANH_SH);
    t_over = (s5_ut_r >> (TANH_SH + TB)) != '0;
    t_f    = 16'(s5_ut_r >> (TANH_SH - 16));
    if (s5_ctl_r.mode == gelu_pkg::MODE_TANH) begin
      idx     = t_idx;
      f_nxt   = t_f;
      sat_nxt = s5_ctl_r.big || t_over;
    end else begin
      idx     = e_idx;
      f_nxt   = e_f;
      sat_nxt = e_over;
    end
    k0 = idx;
    k1 = k0 + gelu_pkg::ROM_AW'(1);
    if (s5_ctl_r.mode == gelu_pkg::MODE_TANH) begin
      t0_nxt = gelu_pkg::TANH_ROM[k0];
      t1_nxt = gelu_pkg::TANH_ROM[k1];
    end else begin
      t0_nxt = gelu_pkg::ERF_ROM[k0];
      t1_nxt = gelu_pkg::ERF_ROM[k1];
    end
    // upper neighbour of the last knot is the clamp value
    if (k0 == '1) begin
      t1_nxt = gelu_pkg::KNOT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    s6_sat_r <= sat_nxt;
    s6_t0_r  <= t0_nxt;
    s6_t1_r  <= t1_nxt;
    s6_f_r   <= f_nxt;
  end

  // stage 7: linear interpolation in Q32, clamped to one
  logic signed [RW:0]     d;
  logic signed [GS_W-1:0] g_s;
  logic [G_W-1:0]         g_nxt;
  logic [G_W-1:0]         s7_g_r;

  always_comb begin
    d   = $signed({1'b0, s6_t1_r}) - $signed({1'b0, s6_t0_r});
    g_s = $signed({1'b0, s6_t0_r, 16'd0}) + d * $signed({1'b0, s6_f_r});
    if (s6_sat_r || g_s[GS_W-1] || (g_s > $signed({2'b00, G_ONE}))) begin
      g_nxt = G_ONE;
    end else begin
      g_nxt = G_W'(g_s);
    end
  end

  always_ff @(posedge clk) begin
    s7_g_r <= g_nxt;
  end

  // stage 8: x*(1 +/- g)
  logic [M_W-1:0] m;
  logic [N_W-1:0] n_nxt;
  logic [N_W-1:0] s8_n_r;

  assign m     = s7_ctl_r.neg ? (M_ONE - M_W'(s7_g_r)) : (M_ONE + M_W'(s7_g_r));
  assign n_nxt = s7_ctl_r.a * m;

  always_ff @(posedge clk) begin
    s8_n_r <= n_nxt;
  end

  // output stage: round, apply sign, saturate
  logic [MAG_W-1:0]           mag;
  logic signed [A_W-1:0]      y_nxt;
  logic                       out_strobe_r;
  logic signed [A_W-1:0]      out_sample_r;

  always_comb begin
    mag = MAG_W'((s8_n_r + N_HALF) >> 33);
    if (!s8_ctl_r.neg) begin
      y_nxt = (mag > MAG_W'(32767)) ? A_W'(16'h7fff) : A_W'(mag);
    end else begin
      y_nxt = (mag > MAG_W'(32768)) ? A_W'(16'h8000) : A_W'(MAG_W'(0) - mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s8_ctl_r.v;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= y_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_sample_out = out_sample_r;

  // every item taken gives exactly one result after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("item did not reach the output after the pipeline latency");

  // no rising result strobe without an item in the last stage
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(s8_ctl_r.v))
    else $error("result strobe without an item in flight");

  // a tanh item with a large input always takes the clamp value
  a_big_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_ctl_r.v && s5_ctl_r.mode == gelu_pkg::MODE_TANH && s5_ctl_r.big) |=> s6_sat_r)
    else $error("large tanh argument not clamped");

  // interpolated value never exceeds one
  a_g_range: assert property (@(posedge clk) disable iff (!rst_n)
    s7_ctl_r.v |-> (s7_g_r <= G_ONE))
    else $error("interpolated function value above one");

  // a non-negative input never gives a negative result
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (s8_ctl_r.v && !s8_ctl_r.neg) |=> !out_sample_out[A_W-1])
    else $error("negative result for a non-negative item");

endmodule
